[hdl/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BYTES_W    = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned BSIZE_W    = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned BLK_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Internal widths: a run length, a block pointer that may step past the heap end,
  // the byte count of a free run, a block offset in bytes and a block product.
  localparam int unsigned ENTRY_W = 7;
  localparam int unsigned PTR_W   = 8;
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned PACC_W  = 23;
  localparam int unsigned PROD_W  = 24;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OWNER = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST = 32'd0;
  localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST   = 16'd16;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST  = 7'd64;

  // One request.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  address;
  } ffba_req_t;

  // One response.
  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] granted_address;
    logic [BLK_W-1:0]  start_block;
  } ffba_rsp_t;

endpackage

`default_nettype wire

[hdl/ffba_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator with its run table and sequencer.
//
// Usage: a heap of equal blocks starts at base_address. Requests arrive on the
// in channel (valid/ready) as allocate, free or ownership test; each request
// gives exactly one response on the out channel (valid/ready). Configuration
// registers are written through the cfg port; the user must write them only
// while no request is in flight, which the block does not enforce. One request
// is worked on at a time. An allocate reads the run table one entry per cycle,
// skipping whole runs, until a fit or the end of the live heap; a free
// compares one block offset per cycle, until a match or the end of the live
// heap; an ownership test multiplies once for the heap size. The response is
// loaded into an output register from the response state, and the next
// request is taken once the sequencer is back in idle. The run-table RAM port
// and the serial block walk set these rates.
// Reset empties the heap at once (per-entry valid flags) and loads the
// default configuration. If the receiver stalls, the response waits in the
// output register; a further request may be taken and worked on, and its
// response waits in the sequencer until the register frees.
`default_nettype none

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire ffba_req_t             in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ffba_rsp_t                  out_rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [PTR_W-1:0] MAX_N = PTR_W'(MAX_BLOCKS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_FREE = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RESP = 3'd4;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [COUNT_W-1:0] count_q;

  // Sequencer state.
  logic [2:0]         state_q, state_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic [ADDR_W:0]    off_q, off_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [PTR_W-1:0]   rs_q, rs_d;
  logic [ENTRY_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PACC_W-1:0]  pacc_q, pacc_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic               fail_q, fail_d;

  // Run-table access.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [MAX_BLOCKS-1:0] valid_q;
  logic               vld_rd_q;
  logic               free_clr;

  // Output register.
  logic      out_valid_q;
  ffba_rsp_t out_rsp_q, rsp_d;
  logic      rsp_load;

  // Datapath helpers.
  logic [PTR_W-1:0]   live_n;
  logic [ADDR_W:0]    off_new;
  logic [ENTRY_W-1:0] entry_val;
  logic [PTR_W-1:0]   run_start;
  logic [ENTRY_W-1:0] cnt_inc;
  logic [ACC_W-1:0]   acc_sum;
  logic               enough;
  logic [PTR_W-1:0]   ptr_inc;
  logic [PTR_W-1:0]   scan_next;
  logic               free_match;
  logic [PTR_W-1:0]   mul_op;
  logic [PROD_W-1:0]  mul_res;
  logic               owned;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_ADDRESS_RST;
      bsize_q <= BLOCK_SIZE_RST;
      count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE_ADDRESS: base_q  <= cfg_data_i[ADDR_W-1:0];
        REG_BLOCK_SIZE:   bsize_q <= cfg_data_i[BSIZE_W-1:0];
        REG_BLOCK_COUNT:  count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Blocks in the heap, capped by the table depth.
  assign live_n = (PTR_W'(count_q) > MAX_N) ? MAX_N : PTR_W'(count_q);

  // Byte offset of the request address from the heap base; the top bit flags below-base.
  assign off_new = {1'b0, in_req_i.address} - {1'b0, base_q};

  // Run table storage.
  ffba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_run_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Valid flags make the table read as empty after reset; the flag is read with the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      vld_rd_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (free_clr) begin
        valid_q[ptr_q[AW-1:0]] <= 1'b0;
      end
    end
  end

  // Scan step: a used entry skips its run, a free one extends the current run.
  assign entry_val = vld_rd_q ? ram_rdata : '0;
  assign run_start = (cnt_q == '0) ? ptr_q : rs_q;
  assign cnt_inc   = cnt_q + ENTRY_W'(1);
  assign acc_sum   = acc_q + ACC_W'(bsize_q);
  assign enough    = (acc_sum >= ACC_W'(bytes_q));
  assign ptr_inc   = ptr_q + PTR_W'(1);
  assign scan_next = (entry_val != '0) ? (ptr_q + PTR_W'(entry_val)) : ptr_inc;

  // Free step: the block offset in bytes matches the request offset exactly.
  assign free_match = (ADDR_W'(pacc_q) == off_q[ADDR_W-1:0]);

  // One multiplier: start block times block size, or heap size for the ownership test.
  assign mul_op  = (kind_q == KIND_ALLOC) ? rs_q : live_n;
  assign mul_res = PROD_W'(mul_op) * PROD_W'(bsize_q);

  assign owned = !off_q[ADDR_W] && (off_q[ADDR_W-1:0] < ADDR_W'(prod_q));

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    bytes_d   = bytes_q;
    off_d     = off_q;
    ptr_d     = ptr_q;
    rs_d      = rs_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    pacc_d    = pacc_q;
    prod_d    = prod_q;
    fail_d    = fail_q;
    ram_we    = 1'b0;
    ram_waddr = run_start[AW-1:0];
    ram_wdata = cnt_inc;
    ram_raddr = ptr_q[AW-1:0];
    free_clr  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_valid_i) begin
          kind_d  = in_req_i.kind;
          bytes_d = in_req_i.request_bytes;
          off_d   = off_new;
          ptr_d   = '0;
          cnt_d   = '0;
          acc_d   = '0;
          pacc_d  = '0;
          fail_d  = 1'b1;
          case (in_req_i.kind)
            KIND_ALLOC: state_d = (live_n == '0) ? ST_RESP : ST_SCAN;
            KIND_FREE:  state_d = ((live_n == '0) || off_new[ADDR_W]) ? ST_RESP : ST_FREE;
            KIND_OWNER: state_d = ST_MUL;
            default:    state_d = ST_RESP;
          endcase
        end
      end

      ST_SCAN: begin
        if ((entry_val == '0) && enough) begin
          // Fit found: record the run length at its first block.
          ram_we  = 1'b1;
          rs_d    = run_start;
          fail_d  = 1'b0;
          state_d = ST_MUL;
        end else if (scan_next >= live_n) begin
          state_d = ST_RESP;
        end else begin
          ptr_d     = scan_next;
          ram_raddr = scan_next[AW-1:0];
          if (entry_val != '0) begin
            cnt_d = '0;
            acc_d = '0;
          end else begin
            rs_d  = run_start;
            cnt_d = cnt_inc;
            acc_d = acc_sum;
          end
        end
      end

      ST_FREE: begin
        if (free_match) begin
          free_clr = 1'b1;
          fail_d   = 1'b0;
          state_d  = ST_RESP;
        end else if (ptr_inc >= live_n) begin
          state_d = ST_RESP;
        end else begin
          ptr_d  = ptr_inc;
          pacc_d = pacc_q + PACC_W'(bsize_q);
        end
      end

      ST_MUL: begin
        prod_d  = mul_res;
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fail_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    bytes_q <= bytes_d;
    off_q   <= off_d;
    ptr_q   <= ptr_d;
    rs_q    <= rs_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    pacc_q  <= pacc_d;
    prod_q  <= prod_d;
  end

  // Response composition per operation.
  always_comb begin
    rsp_d.status          = 1'b1;
    rsp_d.granted_address = '0;
    rsp_d.start_block     = '0;
    case (kind_q)
      KIND_ALLOC: begin
        rsp_d.status = fail_q;
        if (!fail_q) begin
          rsp_d.granted_address = base_q + ADDR_W'(prod_q);
          rsp_d.start_block     = rs_q[BLK_W-1:0];
        end
      end
      KIND_FREE: begin
        rsp_d.status = fail_q;
        if (!fail_q) begin
          rsp_d.start_block = ptr_q[BLK_W-1:0];
        end
      end
      KIND_OWNER: rsp_d.status = !owned;
      default:    rsp_d.status = 1'b1;
    endcase
  end

  // Output register: loads when empty or being drained.
  assign rsp_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The scan pointer never leaves the live heap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q < live_n))
    else $error("scan pointer beyond heap end");

  // A free walk only starts for an address at or above the base.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FREE) |-> !off_q[ADDR_W])
    else $error("free walk with address below base");

  // Recorded runs are never empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata != '0))
    else $error("zero-length run recorded");

  // A finished response is held while the output register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESP) && out_valid_q && !out_ready_i) |=> (state_q == ST_RESP))
    else $error("response dropped under stall");

endmodule

`default_nettype wire
